// ===== hdl/pcfd_pkg.sv =====
// pcfd_pkg: shared types, lookup tables and divider step for the pll frequency decoder
`timescale 1ns / 1ps
`default_nettype none
package pcfd_pkg;

    localparam logic       CFG_FPGA_MODE   = 1'b0;
    localparam logic       CFG_REF_CLOCK   = 1'b1;
    localparam logic [9:0] REF_RESET_MHZ   = 10'd125;
    localparam logic [19:0] FPGA_CLOCK_MHZ = 20'd6;

    localparam logic [2:0] PRESCALE_TBL [4] = '{3'd1, 3'd3, 3'd2, 3'd4};

    localparam logic [5:0] PREDIV_TBL [32] = '{
        6'd1, 6'd16, 6'd17, 6'd30, 6'd13, 6'd18, 6'd7, 6'd31,
        6'd14, 6'd11, 6'd19, 6'd21, 6'd27, 6'd8, 6'd23, 6'd32,
        6'd15, 6'd29, 6'd12, 6'd6, 6'd10, 6'd20, 6'd26, 6'd22,
        6'd28, 6'd5, 6'd9, 6'd25, 6'd4, 6'd24, 6'd3, 6'd2
    };

    localparam logic [5:0] FORWARD_TBL [32] = '{
        6'd1, 6'd2, 6'd28, 6'd27, 6'd22, 6'd21, 6'd30, 6'd29,
        6'd24, 6'd23, 6'd12, 6'd11, 6'd16, 6'd15, 6'd32, 6'd31,
        6'd26, 6'd25, 6'd20, 6'd19, 6'd10, 6'd9, 6'd14, 6'd13,
        6'd18, 6'd17, 6'd8, 6'd7, 6'd6, 6'd5, 6'd4, 6'd3
    };

    localparam logic [7:0] FEEDBACK_TBL [256] = '{
        8'd1, 8'd123, 8'd117, 8'd251, 8'd245, 8'd69, 8'd111, 8'd125, 8'd119, 8'd95,
        8'd105, 8'd197, 8'd239, 8'd163, 8'd63, 8'd253, 8'd247, 8'd187, 8'd57, 8'd223,
        8'd233, 8'd207, 8'd157, 8'd71, 8'd113, 8'd15, 8'd89, 8'd37, 8'd191, 8'd19,
        8'd99, 8'd127, 8'd121, 8'd109, 8'd93, 8'd61, 8'd185, 8'd155, 8'd13, 8'd97,
        8'd107, 8'd11, 8'd9, 8'd81, 8'd31, 8'd49, 8'd83, 8'd199, 8'd241, 8'd33,
        8'd181, 8'd143, 8'd217, 8'd173, 8'd51, 8'd165, 8'd65, 8'd85, 8'd151, 8'd147,
        8'd227, 8'd41, 8'd201, 8'd255, 8'd249, 8'd243, 8'd195, 8'd237, 8'd221, 8'd231,
        8'd35, 8'd189, 8'd59, 8'd183, 8'd79, 8'd29, 8'd141, 8'd215, 8'd145, 8'd225,
        8'd235, 8'd219, 8'd27, 8'd139, 8'd137, 8'd135, 8'd175, 8'd209, 8'd159, 8'd53,
        8'd45, 8'd177, 8'd211, 8'd23, 8'd167, 8'd73, 8'd115, 8'd67, 8'd103, 8'd161,
        8'd55, 8'd205, 8'd87, 8'd17, 8'd91, 8'd153, 8'd7, 8'd47, 8'd179, 8'd171,
        8'd149, 8'd39, 8'd193, 8'd229, 8'd77, 8'd213, 8'd25, 8'd133, 8'd43, 8'd21,
        8'd101, 8'd203, 8'd5, 8'd169, 8'd75, 8'd131, 8'd3, 8'd129, 8'd1, 8'd250,
        8'd244, 8'd124, 8'd118, 8'd196, 8'd238, 8'd252, 8'd246, 8'd222, 8'd232, 8'd70,
        8'd112, 8'd36, 8'd190, 8'd126, 8'd120, 8'd60, 8'd184, 8'd96, 8'd106, 8'd80,
        8'd30, 8'd198, 8'd240, 8'd142, 8'd216, 8'd164, 8'd64, 8'd146, 8'd226, 8'd254,
        8'd248, 8'd236, 8'd220, 8'd188, 8'd58, 8'd28, 8'd140, 8'd224, 8'd234, 8'd138,
        8'd136, 8'd208, 8'd158, 8'd176, 8'd210, 8'd72, 8'd114, 8'd160, 8'd54, 8'd16,
        8'd90, 8'd46, 8'd178, 8'd38, 8'd192, 8'd212, 8'd24, 8'd20, 8'd100, 8'd168,
        8'd74, 8'd128, 8'd122, 8'd116, 8'd68, 8'd110, 8'd94, 8'd104, 8'd162, 8'd62,
        8'd186, 8'd56, 8'd206, 8'd156, 8'd14, 8'd88, 8'd18, 8'd98, 8'd108, 8'd92,
        8'd154, 8'd12, 8'd10, 8'd8, 8'd48, 8'd82, 8'd32, 8'd180, 8'd172, 8'd50,
        8'd84, 8'd150, 8'd40, 8'd200, 8'd242, 8'd194, 8'd230, 8'd34, 8'd182, 8'd78,
        8'd214, 8'd144, 8'd218, 8'd26, 8'd134, 8'd174, 8'd52, 8'd44, 8'd22, 8'd166,
        8'd66, 8'd102, 8'd204, 8'd86, 8'd152, 8'd6, 8'd170, 8'd148, 8'd228, 8'd76,
        8'd132, 8'd42, 8'd202, 8'd4, 8'd130, 8'd2
    };

    typedef struct packed {
        logic       fpga;
        logic       bad;
        logic [9:0] ref_mhz;
        logic [2:0] mps;
        logic [7:0] fb;
        logic [5:0] pdv;
        logic [2:0] aps;
        logic [5:0] fwd;
    } t_lookup;

    typedef struct packed {
        logic        fpga;
        logic        bad;
        logic [11:0] num_a;
        logic [7:0]  fb;
        logic [7:0]  den_a;
        logic [5:0]  fwd;
    } t_mult;

    typedef struct packed {
        logic        fpga;
        logic        bad;
        logic [19:0] q;
        logic [12:0] rem;
        logic [12:0] den;
    } t_div;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    function automatic t_div div_step(input t_div d);
        logic [13:0] trial;
        t_div        o;
        o     = d;
        trial = {d.rem, d.q[19]};
        o.q   = {d.q[18:0], 1'b0};
        if (trial >= {1'b0, d.den}) begin
            o.rem  = 13'(trial - {1'b0, d.den});
            o.q[0] = 1'b1;
        end else begin
            o.rem = trial[12:0];
        end
        return o;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/pll_clock_frequency_decode_core.sv =====
// pll_clock_frequency_decode_core: pipelined pll control word to clock frequency decoder
//
//  channel | direction | handshake          | payload
//  in      | input     | i_valid / o_ready  | i_pll_ctrl[31:0]
//  out     | output    | o_valid / i_ready  | o_clock_mhz[19:0], o_status
//  cfg     | input     | i_cfg_we           | i_cfg_idx, i_cfg_data[9:0]
//
// stages: lookup, two multiply stages, ten divider stages of two quotient bits
// one word per cycle sustained while the output is not stalled; the 20-bit restoring divider chain sets the depth
// reset clears all stage valid bits and sets ref clock to 125, fpga mode off
// a stall on the output fills empty stages first; a word is never dropped or repeated
`timescale 1ns / 1ps
`default_nettype none
module pll_clock_frequency_decode_core
    import pcfd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [9:0]  i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_pll_ctrl,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [19:0]      o_clock_mhz,
    output logic             o_status
);

    localparam int NDIV = 10;
    localparam int NST  = NDIV + 3;

    logic       r_fpga_mode;
    logic [9:0] r_ref_mhz;

    logic [NST-1:0] r_v;
    logic [NST-1:0] adv;

    t_lookup r_lk;
    t_lookup n_lk;
    t_mult   r_mu;
    t_mult   n_mu;
    t_div    r_dv [NDIV+1];
    t_div    n_dv [NDIV+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fpga_mode <= 1'b0;
            r_ref_mhz   <= REF_RESET_MHZ;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FPGA_MODE: r_fpga_mode <= i_cfg_data[0];
                CFG_REF_CLOCK: r_ref_mhz   <= i_cfg_data;
                default:       r_ref_mhz   <= r_ref_mhz;
            endcase
        end
    end

    // each stage loads when empty or when its successor moves on
    always_comb begin
        adv[NST-1] = !r_v[NST-1] || i_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    assign o_ready = adv[0];

    always_comb begin
        n_lk.fpga    = r_fpga_mode;
        n_lk.bad     = i_pll_ctrl[31];
        n_lk.ref_mhz = r_ref_mhz;
        n_lk.mps     = PRESCALE_TBL[i_pll_ctrl[10:9]];
        n_lk.fb      = FEEDBACK_TBL[i_pll_ctrl[8:1]];
        n_lk.pdv     = PREDIV_TBL[i_pll_ctrl[30:26]];
        n_lk.aps     = PRESCALE_TBL[i_pll_ctrl[25:24]];
        n_lk.fwd     = FORWARD_TBL[i_pll_ctrl[23:19]];

        n_mu.fpga  = r_lk.fpga;
        n_mu.bad   = r_lk.bad;
        n_mu.num_a = 12'(r_lk.ref_mhz) * 12'(r_lk.mps);
        n_mu.fb    = r_lk.fb;
        n_mu.den_a = 8'(r_lk.pdv) * 8'(r_lk.aps);
        n_mu.fwd   = r_lk.fwd;

        n_dv[0].fpga = r_mu.fpga;
        n_dv[0].bad  = r_mu.bad;
        n_dv[0].q    = 20'(r_mu.num_a) * 20'(r_mu.fb);
        n_dv[0].rem  = '0;
        n_dv[0].den  = 13'(r_mu.den_a) * 13'(r_mu.fwd);
        for (int k = 1; k <= NDIV; k++) begin
            n_dv[k] = div_step(div_step(r_dv[k-1]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NST; k++) begin
                if (adv[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) r_lk <= n_lk;
        if (adv[1]) r_mu <= n_mu;
        for (int k = 0; k <= NDIV; k++) begin
            if (adv[k+2]) r_dv[k] <= n_dv[k];
        end
    end

    assign o_valid     = r_v[NST-1];
    assign o_status    = !r_dv[NDIV].fpga && r_dv[NDIV].bad;
    assign o_clock_mhz = r_dv[NDIV].fpga ? FPGA_CLOCK_MHZ :
                         (r_dv[NDIV].bad ? 20'd0 : r_dv[NDIV].q);

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_clock_mhz == 20'd0)
        else $error("invalid status with nonzero frequency");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready && (&r_v))
        else $error("input stalled while pipeline has room");

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_dv[NDIV].rem < r_dv[NDIV].den || r_dv[NDIV].den == 13'd0)
        else $error("divider remainder out of range");

endmodule
`default_nettype wire
